@@ rtl/core/least_laxity_first_scheduler_assert.svh @@
// Assertion macros used by the checker of the least-laxity-first scheduler.
`ifndef LEAST_LAXITY_FIRST_SCHEDULER_ASSERT_SVH
`define LEAST_LAXITY_FIRST_SCHEDULER_ASSERT_SVH

// Checked on every rising edge outside reset.
`define LLFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define LLFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/llfs_pkg.sv @@
// Shared types and constants of the least-laxity-first scheduler.
`default_nettype none
package llfs_pkg;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 112;
  localparam int REQ_W      = 2;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 16;
  localparam int MASK_W     = 16;
  localparam int FTIME_W    = 24;
  localparam int RESP_W     = 25;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_TICK = 2'd1,
    REQ_READ = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LIMIT  = 2'd1,
    ST_BADIDX = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_DECODE,
    OP_SCAN,
    OP_PREEMPT,
    OP_RUN,
    OP_IDLE_TICK,
    OP_DEADLINE,
    OP_ADV,
    OP_STAT
  } op_t;

  typedef enum logic [1:0] {
    A_K,
    A_CUR,
    A_BEST,
    A_REQ
  } asel_t;

  typedef struct packed {
    op_t   op;
    asel_t asel;
    logic  start;
    logic  load_out;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             rd_ok;
    logic             at_limit;
    logic             found;
    logic             do_pre;
  } sts_t;

  typedef struct packed {
    logic [RESP_W-1:0]  resp;
    logic [FTIME_W-1:0] fin;
    logic [CNT_W-1:0]   missed;
    logic [CNT_W-1:0]   preempts;
    status_t            status;
    logic [MASK_W-1:0]  mask;
    logic               finished;
    logic [IDX_W-1:0]   ptask;
    logic               preempted;
    logic               started;
    logic               idle;
    logic [IDX_W-1:0]   run;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/core/llfs_ctrl.sv @@
// Sequencer of the scheduler: walks each request through its datapath steps.
`default_nettype none
module llfs_ctrl #(
  parameter int MAX_TASKS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  input  wire llfs_pkg::sts_t         sts,
  output llfs_pkg::cmd_t              cmd,
  output logic [((MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1)-1:0] k
);

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam logic [IW-1:0] LAST = IW'(MAX_TASKS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_SCAN, S_SCAN_END, S_PRE, S_PRE_WR, S_RUN, S_RUN_WR,
    S_DL_RD, S_DL_WR, S_ADV, S_RD_RD, S_RD_WR, S_EMIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic          in_ready_r, in_ready_nxt;
  logic          out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '{op: llfs_pkg::OP_NONE, asel: llfs_pkg::A_K, start: 1'b0,
                      load_out: 1'b0};
    state_nxt     = state_r;
    k_nxt         = k_r;
    in_ready_nxt  = in_ready_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_ready_r) begin
          cmd.start    = 1'b1;
          in_ready_nxt = 1'b0;
          state_nxt    = S_DEC;
        end
      end
      S_DEC: begin
        cmd.op = llfs_pkg::OP_DECODE;
        k_nxt  = '0;
        case (sts.req)
          llfs_pkg::REQ_TICK: state_nxt = sts.at_limit ? S_EMIT : S_SCAN;
          llfs_pkg::REQ_READ: state_nxt = sts.rd_ok ? S_RD_RD : S_EMIT;
          default:            state_nxt = S_EMIT;
        endcase
      end
      S_SCAN: begin
        cmd.asel = llfs_pkg::A_K;
        cmd.op   = (k_r != '0) ? llfs_pkg::OP_SCAN : llfs_pkg::OP_NONE;
        if (k_r == LAST) begin
          state_nxt = S_SCAN_END;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_SCAN_END: begin
        cmd.op    = llfs_pkg::OP_SCAN;
        state_nxt = S_PRE;
      end
      S_PRE: begin
        if (sts.do_pre) begin
          cmd.asel  = llfs_pkg::A_CUR;
          state_nxt = S_PRE_WR;
        end else begin
          state_nxt = S_RUN;
        end
      end
      S_PRE_WR: begin
        cmd.op    = llfs_pkg::OP_PREEMPT;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        k_nxt = '0;
        if (sts.found) begin
          cmd.asel  = llfs_pkg::A_BEST;
          state_nxt = S_RUN_WR;
        end else begin
          cmd.op    = llfs_pkg::OP_IDLE_TICK;
          state_nxt = S_DL_RD;
        end
      end
      S_RUN_WR: begin
        cmd.op    = llfs_pkg::OP_RUN;
        state_nxt = S_DL_RD;
      end
      S_DL_RD: begin
        cmd.asel  = llfs_pkg::A_K;
        state_nxt = S_DL_WR;
      end
      S_DL_WR: begin
        cmd.op = llfs_pkg::OP_DEADLINE;
        if (k_r == LAST) begin
          state_nxt = S_ADV;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_DL_RD;
        end
      end
      S_ADV: begin
        cmd.op    = llfs_pkg::OP_ADV;
        state_nxt = S_EMIT;
      end
      S_RD_RD: begin
        cmd.asel  = llfs_pkg::A_REQ;
        state_nxt = S_RD_WR;
      end
      S_RD_WR: begin
        cmd.op    = llfs_pkg::OP_STAT;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          in_ready_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = in_ready_r;
  assign out_tvalid = out_valid_r;
  assign k          = k_r;

endmodule
`default_nettype wire

@@ rtl/core/llfs_dp.sv @@
// Datapath of the scheduler: task table, time base, selection and result register.
`default_nettype none
module llfs_dp #(
  parameter int MAX_TASKS = 16,
  parameter int TIME_BITS = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [llfs_pkg::REQ_W-1:0]        in_tuser,
  input  wire logic [llfs_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire llfs_pkg::cmd_t                    cmd,
  input  wire logic [((MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1)-1:0] k,
  output llfs_pkg::sts_t                         sts,
  output logic [llfs_pkg::OUT_DATA_W-1:0]        out_tdata
);

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int T  = TIME_BITS;
  localparam int LW = ((TIME_BITS > 16) ? TIME_BITS : 16) + 2;
  localparam int CW = llfs_pkg::CNT_W;

  typedef struct packed {
    logic          periodic;
    logic [15:0]   exec;
    logic [T-1:0]  period;
    logic [T-1:0]  rel;
    logic [T-1:0]  deadline;
    logic [15:0]   rem;
    logic [CW-1:0] pre_cnt;
    logic [CW-1:0] miss_cnt;
    logic [T-1:0]  fin;
  } entry_t;

  entry_t entry_mem [MAX_TASKS];

  logic [1:0]     req_r;
  logic [3:0]     idx_r;
  logic           en_r, per_r;
  logic [15:0]    exec_r;
  logic [T-1:0]   period_r, fdl_r, rel_r;

  logic [MAX_TASKS-1:0] valid_r, valid_nxt;
  logic [T-1:0]         time_r, time_nxt;
  logic [IW-1:0]        cur_r, cur_nxt;
  logic                 cur_vld_r, cur_vld_nxt;
  logic                 last_done_r, last_done_nxt;
  logic [IW-1:0]        best_r, best_nxt;
  logic signed [LW-1:0] best_lax_r, best_lax_nxt;
  logic                 found_r, found_nxt;
  llfs_pkg::res_t       res_r, res_nxt;
  logic [llfs_pkg::OUT_DATA_W-1:0] out_r;

  entry_t        rd_r;
  logic          rd_vld_r;
  logic [IW-1:0] addr_r, addr;

  logic          we;
  logic [IW-1:0] wa;
  entry_t        wd;

  logic                 idx_ok;
  logic [IW-1:0]        idx_a;
  logic [T-1:0]         tp1;
  logic signed [LW-1:0] lax;
  logic                 elig;
  logic [15:0]          rem_dec;
  logic [T:0]           dsum;
  logic signed [T:0]    resp;
  logic [llfs_pkg::MASK_W-1:0] hit_bits;

  assign idx_ok = 32'(idx_r) < MAX_TASKS;
  assign idx_a  = IW'(idx_r);
  assign tp1    = time_r + 1'b1;
  assign lax    = $signed(LW'(rd_r.deadline)) - $signed(LW'(time_r)) - $signed(LW'(rd_r.rem));
  assign elig   = rd_vld_r && (rd_r.rem != '0) && (rd_r.periodic || (rd_r.rel <= time_r));
  assign rem_dec = rd_r.rem - 1'b1;
  assign dsum   = {1'b0, rd_r.deadline} + {1'b0, rd_r.period};
  assign resp   = $signed({1'b0, rd_r.fin}) - $signed({1'b0, rd_r.rel});

  always_comb begin
    hit_bits = '0;
    for (int i = 0; i < llfs_pkg::MASK_W; i++) begin
      if (32'(addr_r) == i) begin
        hit_bits[i] = 1'b1;
      end
    end
  end

  assign sts.req      = req_r;
  assign sts.rd_ok    = idx_ok && valid_r[idx_a];
  assign sts.at_limit = (time_r == '1);
  assign sts.found    = found_r;
  assign sts.do_pre   = cur_vld_r && !last_done_r && (!found_r || (cur_r != best_r));

  always_comb begin
    case (cmd.asel)
      llfs_pkg::A_CUR:  addr = cur_r;
      llfs_pkg::A_BEST: addr = best_r;
      llfs_pkg::A_REQ:  addr = idx_a;
      default:          addr = k;
    endcase
  end

  always_comb begin
    valid_nxt     = valid_r;
    time_nxt      = time_r;
    cur_nxt       = cur_r;
    cur_vld_nxt   = cur_vld_r;
    last_done_nxt = last_done_r;
    best_nxt      = best_r;
    best_lax_nxt  = best_lax_r;
    found_nxt     = found_r;
    res_nxt       = res_r;
    we            = 1'b0;
    wa            = addr_r;
    wd            = rd_r;
    if (cmd.start) begin
      res_nxt   = '0;
      found_nxt = 1'b0;
      best_nxt  = '0;
    end
    case (cmd.op)
      llfs_pkg::OP_DECODE: begin
        case (req_r)
          llfs_pkg::REQ_LOAD: begin
            if (idx_ok) begin
              valid_nxt[idx_a] = en_r;
              we          = 1'b1;
              wa          = idx_a;
              wd.periodic = per_r;
              wd.exec     = exec_r;
              wd.period   = period_r;
              wd.rel      = rel_r;
              wd.deadline = fdl_r;
              wd.rem      = exec_r;
              wd.pre_cnt  = '0;
              wd.miss_cnt = '0;
              wd.fin      = '0;
            end else begin
              res_nxt.status = llfs_pkg::ST_BADIDX;
            end
          end
          llfs_pkg::REQ_TICK: begin
            if (time_r == '1) begin
              res_nxt.status = llfs_pkg::ST_LIMIT;
            end
          end
          llfs_pkg::REQ_READ: begin
            if (!(idx_ok && valid_r[idx_a])) begin
              res_nxt.status = llfs_pkg::ST_BADIDX;
            end
          end
          default: ;
        endcase
      end
      llfs_pkg::OP_SCAN: begin
        if (elig && (!found_r || (lax < best_lax_r))) begin
          found_nxt    = 1'b1;
          best_nxt     = addr_r;
          best_lax_nxt = lax;
        end
      end
      llfs_pkg::OP_PREEMPT: begin
        we                = 1'b1;
        wd.pre_cnt        = (rd_r.pre_cnt == '1) ? rd_r.pre_cnt : rd_r.pre_cnt + 1'b1;
        res_nxt.preempted = 1'b1;
        res_nxt.ptask     = llfs_pkg::IDX_W'(cur_r);
      end
      llfs_pkg::OP_RUN: begin
        we              = 1'b1;
        wd.rem          = rem_dec;
        res_nxt.run     = llfs_pkg::IDX_W'(best_r);
        res_nxt.started = !cur_vld_r || (cur_r != best_r);
        cur_nxt         = best_r;
        cur_vld_nxt     = 1'b1;
        if (rem_dec == '0) begin
          res_nxt.finished = 1'b1;
          last_done_nxt    = 1'b1;
          if (!rd_r.periodic) begin
            wd.fin = time_r;
          end
        end else begin
          last_done_nxt = 1'b0;
        end
      end
      llfs_pkg::OP_IDLE_TICK: begin
        res_nxt.idle = 1'b1;
        cur_vld_nxt  = 1'b0;
      end
      llfs_pkg::OP_DEADLINE: begin
        if (rd_vld_r && (tp1 == rd_r.deadline)) begin
          we = 1'b1;
          if (rd_r.rem != '0) begin
            wd.miss_cnt  = (rd_r.miss_cnt == '1) ? rd_r.miss_cnt : rd_r.miss_cnt + 1'b1;
            res_nxt.mask = res_r.mask | hit_bits;
            last_done_nxt = 1'b1;
            if (!rd_r.periodic) begin
              wd.fin = time_r;
            end
          end
          if (rd_r.periodic) begin
            wd.rem      = rd_r.exec;
            wd.deadline = dsum[T] ? '1 : dsum[T-1:0];
          end else begin
            wd.rem = '0;
          end
        end
      end
      llfs_pkg::OP_ADV: begin
        time_nxt = tp1;
      end
      llfs_pkg::OP_STAT: begin
        res_nxt.preempts = rd_r.pre_cnt;
        res_nxt.missed   = rd_r.miss_cnt;
        if (!rd_r.periodic) begin
          res_nxt.fin  = llfs_pkg::FTIME_W'(rd_r.fin);
          res_nxt.resp = llfs_pkg::RESP_W'(resp);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      entry_mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    rd_r     <= entry_mem[addr];
    rd_vld_r <= valid_r[addr];
    addr_r   <= addr;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_r    <= in_tuser;
      idx_r    <= in_tdata[3:0];
      en_r     <= in_tdata[4];
      per_r    <= in_tdata[5];
      exec_r   <= in_tdata[21:6];
      period_r <= T'(in_tdata[45:22]);
      fdl_r    <= T'(in_tdata[69:46]);
      rel_r    <= T'(in_tdata[93:70]);
    end
    cur_r      <= cur_nxt;
    best_r     <= best_nxt;
    best_lax_r <= best_lax_nxt;
    found_r    <= found_nxt;
    res_r      <= res_nxt;
    if (cmd.load_out) begin
      out_r <= {1'b0, res_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      time_r      <= '0;
      cur_vld_r   <= 1'b0;
      last_done_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      time_r      <= time_nxt;
      cur_vld_r   <= cur_vld_nxt;
      last_done_r <= last_done_nxt;
    end
  end

  assign out_tdata = out_r;

endmodule
`default_nettype wire

@@ rtl/core/least_laxity_first_scheduler.sv @@
// Least-laxity-first task scheduler: top level joining sequencer and datapath.
//
// Requests enter on the in_ channel; in_tuser carries the request type (load,
// tick, read) and in_tdata the task fields. Every request gives exactly one
// result on the out_ channel. One request is handled at a time: in_tready
// drops when a request is taken and rises again once its result is placed in
// the output register.
// A tick runs through the single table read port: one selection sweep over all
// entries, then a read and write back of each entry for the deadline check.
// A result waits in the output register while out_tready is low; the block
// still takes the next request, and stalls only when a second result is ready.
// Reset (rst_n low, synchronous) empties the task table, clears time and
// the running task, and drops out_tvalid.
`default_nettype none
module least_laxity_first_scheduler #(
  parameter int MAX_TASKS = 16,
  parameter int TIME_BITS = 24
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // req_type
  input  wire logic [llfs_pkg::REQ_W-1:0]     in_tuser,
  // task_index, task_enable, periodic flag, work units per job, period_len,
  // first_deadline, release_at
  input  wire logic [llfs_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // run_task, cpu_idle, started, preempted, preempted_task, finished,
  // missed_mask, status, stat_preemptions, stat_missed, stat_finish_time,
  // stat_response
  output logic [llfs_pkg::OUT_DATA_W-1:0]     out_tdata
);

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  llfs_pkg::cmd_t cmd;
  llfs_pkg::sts_t sts;
  logic [IW-1:0]  k;

  llfs_ctrl #(
    .MAX_TASKS(MAX_TASKS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .sts       (sts),
    .cmd       (cmd),
    .k         (k)
  );

  llfs_dp #(
    .MAX_TASKS(MAX_TASKS),
    .TIME_BITS(TIME_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tuser (in_tuser),
    .in_tdata (in_tdata),
    .cmd      (cmd),
    .k        (k),
    .sts      (sts),
    .out_tdata(out_tdata)
  );

endmodule
`default_nettype wire

@@ rtl/core/llfs_checker.sv @@
// Port-level checks of the scheduler, bound to its top level.
`default_nettype none
`include "least_laxity_first_scheduler_assert.svh"
module llfs_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [111:0] out_tdata
);

  `LLFS_ASSERT_ALWAYS(a_reset_state, !rst_n |=> !out_tvalid && in_tready, "reset state wrong")
  `LLFS_ASSERT(a_one_request, in_tvalid && in_tready |=> !in_tready, "second request taken")
  `LLFS_ASSERT(a_idle_fields, out_tvalid && out_tdata[4] |-> out_tdata[3:0] == 4'd0 && !out_tdata[5], "idle tick shows a task")
  `LLFS_ASSERT(a_error_fields, out_tvalid && out_tdata[29:28] != 2'd0 |-> out_tdata[110:30] == 81'd0 && out_tdata[11:0] == 12'd0, "error result carries data")
  `LLFS_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

bind least_laxity_first_scheduler llfs_checker u_llfs_checker (.*);
`default_nettype wire

@@ tb/tb_least_laxity_first_scheduler.sv @@
// Self-checking testbench for the least-laxity-first scheduler: loads, ticks and reads.
`default_nettype none
module tb_least_laxity_first_scheduler;

  typedef struct packed {
    logic [1:0]  req;
    logic [3:0]  idx;
    logic        en;
    logic        per;
    logic [15:0] exec;
    logic [23:0] period;
    logic [23:0] dline;
    logic [23:0] rel;
  } sched_req_t;

  typedef struct packed {
    logic [3:0]  run;
    logic        idle;
    logic        started;
    logic        preempted;
    logic [3:0]  ptask;
    logic        finished;
    logic [15:0] mask;
    logic [1:0]  status;
    logic [15:0] preempts;
    logic [15:0] missed;
    logic [23:0] fin;
    logic [24:0] resp;
  } sched_res_t;

  localparam logic [23:0] TIME_MAX = 24'hFFFFFF;
  localparam logic [4:0]  NO_TASK = 5'h1F;
  localparam logic [1:0]  REQ_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [llfs_pkg::REQ_W-1:0] in_tuser = '0;
  logic [llfs_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [llfs_pkg::OUT_DATA_W-1:0] out_tdata;

  least_laxity_first_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #1 clk = ~clk;

  // Scheduler state mirror.
  logic        t_valid[16];
  logic        t_per[16];
  logic [15:0] t_exec[16];
  logic [23:0] t_period[16];
  logic [23:0] t_rel[16];
  logic [23:0] t_dline[16];
  logic [15:0] t_rem[16];
  logic [15:0] t_pre[16];
  logic [15:0] t_miss[16];
  logic [23:0] t_fin[16];
  logic [4:0]  cur_task;
  logic        last_done;
  logic [23:0] now;

  sched_req_t pending_reqs[$];
  sched_res_t expected_results[$];
  int errors = 0;
  int n_results = 0;
  int n_ticks = 0;
  int n_misses = 0;
  bit drive_done = 0;
  bit quiet = 0;
  bit long_stall = 0;
  int in_gap = 0;
  int out_gap = 0;

  function automatic logic [15:0] sat16(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic sched_res_t schedule(sched_req_t r);
    sched_res_t o;
    logic [4:0] best;
    longint best_lax, lax;
    logic [24:0] d;
    logic [23:0] t;
    o = '0;
    case (r.req)
      llfs_pkg::REQ_LOAD: begin
        t_valid[r.idx] = r.en;
        t_per[r.idx] = r.per;
        t_exec[r.idx] = r.exec;
        t_period[r.idx] = r.period;
        t_dline[r.idx] = r.dline;
        t_rel[r.idx] = r.rel;
        t_rem[r.idx] = r.exec;
        t_pre[r.idx] = '0;
        t_miss[r.idx] = '0;
        t_fin[r.idx] = '0;
      end
      llfs_pkg::REQ_TICK: begin
        if (now == TIME_MAX) begin
          o.status = llfs_pkg::ST_LIMIT;
        end else begin
          t = now;
          best = NO_TASK;
          best_lax = 64'sh7FFFFFFFFFFFFFFF;
          for (int i = 0; i < 16; i++) begin
            if (!t_valid[i] || t_rem[i] == 0) continue;
            if (!t_per[i] && t_rel[i] > t) continue;
            lax = longint'(t_dline[i]) - longint'(t) - longint'(t_rem[i]);
            if (lax < best_lax) begin
              best_lax = lax;
              best = 5'(i);
            end
          end
          if (cur_task != NO_TASK && cur_task != best && !last_done) begin
            t_pre[cur_task[3:0]] = sat16(t_pre[cur_task[3:0]]);
            o.preempted = 1'b1;
            o.ptask = cur_task[3:0];
          end
          if (best != NO_TASK && cur_task != best) o.started = 1'b1;
          cur_task = best;
          if (best != NO_TASK) begin
            o.run = best[3:0];
            t_rem[best[3:0]] = t_rem[best[3:0]] - 16'd1;
            if (t_rem[best[3:0]] == 0) begin
              o.finished = 1'b1;
              if (!t_per[best[3:0]]) t_fin[best[3:0]] = t;
              last_done = 1'b1;
            end else begin
              last_done = 1'b0;
            end
          end else begin
            o.idle = 1'b1;
          end
          for (int i = 0; i < 16; i++) begin
            if (!t_valid[i] || ({1'b0, t} + 25'd1) != {1'b0, t_dline[i]}) continue;
            if (t_rem[i] > 0) begin
              t_miss[i] = sat16(t_miss[i]);
              o.mask[i] = 1'b1;
              last_done = 1'b1;
              if (!t_per[i]) t_fin[i] = t;
            end
            if (t_per[i]) begin
              d = {1'b0, t_dline[i]} + {1'b0, t_period[i]};
              t_rem[i] = t_exec[i];
              t_dline[i] = d[24] ? TIME_MAX : d[23:0];
            end else begin
              t_rem[i] = '0;
            end
          end
          now = t + 24'd1;
        end
      end
      llfs_pkg::REQ_READ: begin
        if (!t_valid[r.idx]) begin
          o.status = llfs_pkg::ST_BADIDX;
        end else begin
          o.preempts = t_pre[r.idx];
          o.missed = t_miss[r.idx];
          if (!t_per[r.idx]) begin
            o.fin = t_fin[r.idx];
            o.resp = {1'b0, t_fin[r.idx]} - {1'b0, t_rel[r.idx]};
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic sched_res_t unpack_result(logic [llfs_pkg::OUT_DATA_W-1:0] v);
    sched_res_t o;
    o.run = v[3:0];
    o.idle = v[4];
    o.started = v[5];
    o.preempted = v[6];
    o.ptask = v[10:7];
    o.finished = v[11];
    o.mask = v[27:12];
    o.status = v[29:28];
    o.preempts = v[45:30];
    o.missed = v[61:46];
    o.fin = v[85:62];
    o.resp = v[110:86];
    return o;
  endfunction

  // Sender: presents requests at the falling edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(schedule(pending_reqs.pop_front()));
      end
      if (in_tvalid && !in_tready) begin
        // hold the current request
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0 && (quiet || $urandom_range(0, 9) != 0)) begin
        in_tvalid <= 1'b1;
        in_tuser <= pending_reqs[0].req;
        in_tdata <= {2'b00, pending_reqs[0].rel, pending_reqs[0].dline,
                     pending_reqs[0].period, pending_reqs[0].exec, pending_reqs[0].per,
                     pending_reqs[0].en, pending_reqs[0].idx};
      end else begin
        in_tvalid <= 1'b0;
        if (!quiet && pending_reqs.size() > 0) in_gap <= $urandom_range(1, 15);
        if (pending_reqs.size() == 0) drive_done <= 1'b1;
      end
    end
  end

  // Receiver stalls, including one long hold-off.
  always @(negedge clk) begin
    if (rst_n) begin
      if (long_stall) begin
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        out_gap <= $urandom_range(1, 15);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    sched_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = unpack_result(out_tdata);
      n_results++;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result %h", out_tdata);
      end else begin
        want = expected_results.pop_front();
        if (want.mask != 0) n_misses++;
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("Mismatch at result %0d: expected %p, got %p",
                                     n_results, want, got);
        end
      end
    end
  end

  function automatic sched_req_t mk_load(int idx, bit en, bit per, int ex, int prd,
                                         int dl, int rl);
    sched_req_t r;
    r.req = llfs_pkg::REQ_LOAD;
    r.idx = 4'(idx);
    r.en = en;
    r.per = per;
    r.exec = 16'(ex);
    r.period = 24'(prd);
    r.dline = 24'(dl);
    r.rel = 24'(rl);
    return r;
  endfunction

  function automatic sched_req_t mk_op(logic [1:0] kind, int idx);
    sched_req_t r;
    r = '0;
    r.req = kind;
    r.idx = 4'(idx);
    r.exec = 16'($urandom);
    r.period = 24'($urandom);
    r.dline = 24'($urandom);
    r.rel = 24'($urandom);
    r.en = 1'($urandom);
    r.per = 1'($urandom);
    return r;
  endfunction

  // Queued ticks track the time the block will have when later loads arrive.
  task automatic add_ticks(int n);
    for (int k = 0; k < n; k++) begin
      pending_reqs.push_back(mk_op(llfs_pkg::REQ_TICK, $urandom_range(0, 15)));
      n_ticks++;
    end
  endtask

  initial begin
    sched_req_t r;
    int n;
    for (int i = 0; i < 16; i++) begin
      t_valid[i] = 1'b0; t_per[i] = 1'b0; t_exec[i] = '0; t_period[i] = '0; t_rel[i] = '0;
      t_dline[i] = '0; t_rem[i] = '0; t_pre[i] = '0; t_miss[i] = '0; t_fin[i] = '0;
    end
    cur_task = NO_TASK;
    last_done = 1'b0;
    now = '0;

    // Directed: free-entry read, unused type, idle tick, field extremes, misses.
    pending_reqs.push_back(mk_op(llfs_pkg::REQ_READ, 0));
    pending_reqs.push_back(mk_op(REQ_UNUSED, 15));
    add_ticks(1);
    pending_reqs.push_back(mk_load(0, 1, 1, 2, 4, 3, 0));
    pending_reqs.push_back(mk_load(1, 1, 0, 1, 0, 3, 1));
    pending_reqs.push_back(mk_load(15, 1, 0, 65535, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    pending_reqs.push_back(mk_load(2, 1, 0, 5, 0, 0, 0));
    pending_reqs.push_back(mk_load(3, 1, 1, 3, 24'hFFFFFF, 5, 0));
    add_ticks(8);
    for (int i = 0; i < 4; i++) pending_reqs.push_back(mk_op(llfs_pkg::REQ_READ, i));
    pending_reqs.push_back(mk_op(llfs_pkg::REQ_READ, 15));
    pending_reqs.push_back(mk_load(2, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_op(llfs_pkg::REQ_READ, 2));

    // Random: task sets with small timing so ticks reach deadlines.
    n = 0;
    while (n < 530) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          r = mk_load($urandom_range(0, 15), $urandom_range(0, 5) != 0, 1'($urandom),
                      $urandom_range(0, 6), $urandom_range(1, 12),
                      n_ticks + $urandom_range(0, 40), n_ticks + $urandom_range(0, 8));
          if ($urandom_range(0, 30) == 0) begin
            r.exec = 16'($urandom); r.period = 24'($urandom);
            r.dline = 24'($urandom); r.rel = 24'($urandom);
          end
          pending_reqs.push_back(r);
        end
        2: pending_reqs.push_back(mk_op(llfs_pkg::REQ_READ, $urandom_range(0, 15)));
        3: pending_reqs.push_back(mk_op(REQ_UNUSED, $urandom_range(0, 15)));
        default: add_ticks(1);
      endcase
      n++;
    end
    // The time limit lies far beyond the number of ticks in a run of this length.

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Long receiver hold-off, counted here while the sender keeps offering requests.
  initial begin
    wait (rst_n);
    repeat (300) @(posedge clk);
    long_stall = 1'b1;
    repeat (400) @(negedge clk);
    long_stall = 1'b0;
  end

  initial begin
    wait (rst_n);
    repeat (300) @(posedge clk);
    wait (pending_reqs.size() < 60);
    quiet = 1;
    wait (drive_done && expected_results.size() == 0 && !in_tvalid);
    repeat (100) @(posedge clk);
    $display("Covered %0d results, %0d with deadline misses, loads, ticks and reads.",
             n_results, n_misses);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire
